FILE: hw/rtl/assert_macros.svh
// Assertion macros for the RTL files, used by the pipeline top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/cgl_pkg.sv
// Shared types and constants of the colour grading pipeline
package cgl_pkg;

    localparam int LutDimDef = 33;
    localparam int CfgIdxW   = 3;
    localparam int CfgDataW  = 16;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_EXPOSURE   = 3'd0,
        CFG_BRIGHTNESS = 3'd1,
        CFG_CONTRAST   = 3'd2,
        CFG_SATURATION = 3'd3,
        CFG_LUT_SIZE   = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  pixel_red;
        logic [7:0]  pixel_green;
        logic [7:0]  pixel_blue;
        logic [15:0] lut_address;
        logic [15:0] lut_red;
        logic [15:0] lut_green;
        logic [15:0] lut_blue;
    } t_in_item;

    typedef struct packed {
        logic [7:0] graded_red;
        logic [7:0] graded_green;
        logic [7:0] graded_blue;
    } t_out_item;

    typedef struct packed {
        logic [15:0]        exposure_gain;
        logic signed [13:0] brightness_offset;
        logic [15:0]        contrast_gain;
        logic [15:0]        saturation_gain;
        logic [5:0]         lut_size;
    } t_cfg;

    typedef struct packed {
        logic valid;
        logic pixel;
    } t_tag;

    typedef struct packed {
        logic [15:0] addr;
        logic [47:0] data;
    } t_lut_wr;

    typedef struct packed {
        logic             lut_en;
        logic [2:0][15:0] fr;
        logic [2:0][16:0] v;
    } t_lut_side;

endpackage

FILE: hw/rtl/cgl_ifs.sv
// Handshake interfaces of the pixel, result and configuration channels
interface cgl_in_if;
    logic              valid;
    logic              ready;
    cgl_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cgl_out_if;
    logic               valid;
    logic               ready;
    cgl_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cgl_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [cgl_pkg::CfgIdxW-1:0]   index;
    logic [cgl_pkg::CfgDataW-1:0]  data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/cgl_grade.sv
// Exposure, brightness, contrast, saturation and clamp stages
module cgl_grade (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  cgl_pkg::t_tag      i_tag,
    input  cgl_pkg::t_in_item  i_item,
    input  cgl_pkg::t_cfg      i_cfg,
    output cgl_pkg::t_tag      o_tag,
    output cgl_pkg::t_lut_wr   o_wr,
    output logic [2:0][16:0]   o_v
);

    localparam logic signed [16:0] LumaCoef [3] = '{17'sd13933, 17'sd46871, 17'sd4732};

    cgl_pkg::t_tag    r_tag [7];
    cgl_pkg::t_lut_wr r_wr [7];
    cgl_pkg::t_lut_wr w_wr;
    logic [2:0][7:0]  w_pix;

    logic [31:0]        r1_prod [3];
    logic [20:0]        w2_x [3];
    logic signed [22:0] w2_c [3];
    logic signed [39:0] r2_prod [3];
    logic [39:0]        w3_mag [3];
    logic [27:0]        w3_q [3];
    logic signed [28:0] w3_v [3];
    logic signed [28:0] r3_v [3];
    logic signed [45:0] r4_lp [3];
    logic signed [28:0] r4_v [3];
    logic signed [47:0] w5_sum;
    logic [47:0]        w5_mag;
    logic [28:0]        w5_q;
    logic signed [29:0] w5_luma;
    logic signed [29:0] r5_luma;
    logic signed [28:0] r5_v [3];
    logic signed [30:0] w6_d [3];
    logic signed [47:0] r6_prod [3];
    logic signed [29:0] r6_luma;
    logic [47:0]        w7_mag [3];
    logic [35:0]        w7_q [3];
    logic signed [37:0] w7_s [3];
    logic [16:0]        w7_v [3];
    logic [16:0]        r7_v [3];

    assign w_pix = {i_item.pixel_blue, i_item.pixel_green, i_item.pixel_red};
    assign w_wr.addr = i_item.lut_address;
    assign w_wr.data = {i_item.lut_blue, i_item.lut_green, i_item.lut_red};

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w2_x[k] = 21'((33'(r1_prod[k]) + 33'd2048) >> 12);
            w2_c[k] = $signed({2'b00, w2_x[k]})
                    + 23'($signed({i_cfg.brightness_offset, 4'b0000}))
                    - 23'sd32768;
            w3_mag[k] = r2_prod[k][39] ? 40'(-r2_prod[k]) : r2_prod[k];
            w3_q[k] = 28'((w3_mag[k] + 40'd2048) >> 12);
            w3_v[k] = (r2_prod[k][39] ? -$signed({1'b0, w3_q[k]}) : $signed({1'b0, w3_q[k]}))
                    + 29'sd32768;
            w6_d[k] = 31'(r5_v[k]) - 31'(r5_luma);
            w7_mag[k] = r6_prod[k][47] ? 48'(-r6_prod[k]) : r6_prod[k];
            w7_q[k] = 36'((w7_mag[k] + 48'd2048) >> 12);
            w7_s[k] = (r6_prod[k][47] ? -$signed({1'b0, w7_q[k]}) : $signed({1'b0, w7_q[k]}))
                    + 38'(r6_luma);
            if (w7_s[k][37]) begin
                w7_v[k] = 17'd0;
            end else if (w7_s[k] > 38'sd65536) begin
                w7_v[k] = 17'd65536;
            end else begin
                w7_v[k] = w7_s[k][16:0];
            end
        end
        w5_sum = 48'(r4_lp[0]) + 48'(r4_lp[1]) + 48'(r4_lp[2]);
        w5_mag = w5_sum[47] ? 48'(-w5_sum) : w5_sum;
        w5_q = 29'((w5_mag + 48'd32768) >> 16);
        w5_luma = w5_sum[47] ? -$signed({1'b0, w5_q}) : $signed({1'b0, w5_q});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < 7; s++) begin
                r_tag[s] <= '0;
            end
        end else if (i_en) begin
            r_tag[0] <= i_tag;
            for (int s = 1; s < 7; s++) begin
                r_tag[s] <= r_tag[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wr[0] <= w_wr;
            for (int s = 1; s < 7; s++) begin
                r_wr[s] <= r_wr[s-1];
            end
            for (int k = 0; k < 3; k++) begin
                r1_prod[k] <= 32'({w_pix[k], w_pix[k]}) * 32'(i_cfg.exposure_gain);
                r2_prod[k] <= w2_c[k] * $signed({1'b0, i_cfg.contrast_gain});
                r3_v[k]    <= w3_v[k];
                r4_lp[k]   <= r3_v[k] * LumaCoef[k];
                r4_v[k]    <= r3_v[k];
                r5_v[k]    <= r4_v[k];
                r6_prod[k] <= w6_d[k] * $signed({1'b0, i_cfg.saturation_gain});
                r7_v[k]    <= w7_v[k];
            end
            r5_luma <= w5_luma;
            r6_luma <= r5_luma;
        end
    end

    assign o_tag = r_tag[6];
    assign o_wr  = r_wr[6];
    assign o_v   = {r7_v[2], r7_v[1], r7_v[0]};

endmodule

FILE: hw/rtl/cgl_lut_addr.sv
// LUT cell index, fraction and corner address stages
module cgl_lut_addr #(
    parameter int LUT_DIM = cgl_pkg::LutDimDef,
    localparam int AW = $clog2(LUT_DIM**3)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic [5:0]          i_lut_size,
    input  cgl_pkg::t_tag       i_tag,
    input  cgl_pkg::t_lut_wr    i_wr,
    input  logic [2:0][16:0]    i_v,
    output cgl_pkg::t_tag       o_tag,
    output cgl_pkg::t_lut_wr    o_wr,
    output cgl_pkg::t_lut_side  o_side,
    output logic [AW-1:0]       o_addr [8]
);

    localparam int IW  = $clog2(LUT_DIM);
    localparam int SW  = $clog2(LUT_DIM + 1);
    localparam int SSW = $clog2(LUT_DIM * LUT_DIM + 1);
    localparam int CW  = (SW > 6) ? SW : 6;
    localparam int PW  = IW + SSW;

    cgl_pkg::t_tag      r_tag [3];
    cgl_pkg::t_lut_wr   r_wr [3];
    cgl_pkg::t_lut_side r_side [3];
    cgl_pkg::t_lut_side w_side8;

    logic [CW-1:0]  w_size_ext;
    logic [SW-1:0]  w_s;
    logic [SW-1:0]  r_s;
    logic [SSW-1:0] r_ss;
    logic [IW-1:0]  r_sm1;
    logic           r_lut_en;

    logic [16+IW:0] w8_p [3];
    logic [IW-1:0]  w8_i [3];
    logic           w8_top [3];
    logic [IW-1:0]  w8_i0 [3];
    logic [IW-1:0]  w8_i1 [3];
    logic [IW-1:0]  r8_i0 [3];
    logic [IW-1:0]  r8_i1 [3];
    logic [AW-1:0]  r9_zt [2];
    logic [AW-1:0]  r9_yt [2];
    logic [IW-1:0]  r9_x [2];
    logic [AW-1:0]  r10_addr [8];

    assign w_size_ext = CW'(i_lut_size);
    assign w_s = (w_size_ext > CW'(LUT_DIM)) ? SW'(LUT_DIM) : SW'(w_size_ext);

    always_ff @(posedge i_clk) begin
        r_s      <= w_s;
        r_ss     <= SSW'(w_s) * SSW'(w_s);
        r_sm1    <= IW'(w_s - SW'(1));
        r_lut_en <= (w_s >= SW'(2));
    end

    always_comb begin
        w_side8.lut_en = r_lut_en;
        w_side8.v = i_v;
        for (int k = 0; k < 3; k++) begin
            w8_p[k]   = (17 + IW)'(i_v[k]) * (17 + IW)'(r_sm1);
            w8_i[k]   = w8_p[k][16 +: IW];
            w8_top[k] = (w8_i[k] >= r_sm1);
            w8_i0[k]  = w8_top[k] ? r_sm1 : w8_i[k];
            w8_i1[k]  = w8_top[k] ? r_sm1 : IW'(w8_i[k] + IW'(1));
            w_side8.fr[k] = w8_top[k] ? 16'd0 : w8_p[k][15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < 3; s++) begin
                r_tag[s] <= '0;
            end
        end else if (i_en) begin
            r_tag[0] <= i_tag;
            r_tag[1] <= r_tag[0];
            r_tag[2] <= r_tag[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wr[0]   <= i_wr;
            r_wr[1]   <= r_wr[0];
            r_wr[2]   <= r_wr[1];
            r_side[0] <= w_side8;
            r_side[1] <= r_side[0];
            r_side[2] <= r_side[1];
            for (int k = 0; k < 3; k++) begin
                r8_i0[k] <= w8_i0[k];
                r8_i1[k] <= w8_i1[k];
            end
            r9_zt[0] <= AW'(PW'(r8_i0[2]) * PW'(r_ss));
            r9_zt[1] <= AW'(PW'(r8_i1[2]) * PW'(r_ss));
            r9_yt[0] <= AW'(PW'(r8_i0[1]) * PW'(r_s));
            r9_yt[1] <= AW'(PW'(r8_i1[1]) * PW'(r_s));
            r9_x[0]  <= r8_i0[0];
            r9_x[1]  <= r8_i1[0];
            for (int c = 0; c < 8; c++) begin
                r10_addr[c] <= r9_zt[c / 4] + r9_yt[(c / 2) % 2] + AW'(r9_x[c % 2]);
            end
        end
    end

    assign o_tag  = r_tag[2];
    assign o_wr   = r_wr[2];
    assign o_side = r_side[2];
    assign o_addr = r10_addr;

endmodule

FILE: hw/rtl/cgl_lut_mem.sv
// LUT storage: four dual-read copies, each written on every entry update
module cgl_lut_mem #(
    parameter int LUT_DIM = cgl_pkg::LutDimDef,
    localparam int Entries = LUT_DIM**3,
    localparam int AW = $clog2(Entries)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  cgl_pkg::t_tag       i_tag,
    input  cgl_pkg::t_lut_wr    i_wr,
    input  cgl_pkg::t_lut_side  i_side,
    input  logic [AW-1:0]       i_addr [8],
    output cgl_pkg::t_tag       o_tag,
    output cgl_pkg::t_lut_side  o_side,
    output logic [47:0]         o_rd [8]
);

    cgl_pkg::t_tag      r_tag;
    cgl_pkg::t_lut_side r_side;
    logic               w_we;
    logic [AW-1:0]      w_wa;

    assign w_we = i_en && i_tag.valid && !i_tag.pixel && (32'(i_wr.addr) < 32'(Entries));
    assign w_wa = AW'(i_wr.addr);

    for (genvar b = 0; b < 4; b++) begin : g_copy
        logic [47:0] r_mem [Entries];
        logic [47:0] r_rd_a;
        logic [47:0] r_rd_b;

        always_ff @(posedge i_clk) begin
            if (w_we) begin
                r_mem[w_wa] <= i_wr.data;
            end
            if (i_en) begin
                r_rd_a <= r_mem[i_addr[2*b]];
                r_rd_b <= r_mem[i_addr[2*b+1]];
            end
        end

        assign o_rd[2*b]   = r_rd_a;
        assign o_rd[2*b+1] = r_rd_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else if (i_en) begin
            r_tag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= i_side;
        end
    end

    assign o_tag  = r_tag;
    assign o_side = r_side;

endmodule

FILE: hw/rtl/cgl_interp.sv
// Trilinear interpolation: red, green and blue axis blend stages
module cgl_interp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  cgl_pkg::t_tag       i_tag,
    input  cgl_pkg::t_lut_side  i_side,
    input  logic [47:0]         i_rd [8],
    output cgl_pkg::t_tag       o_tag,
    output cgl_pkg::t_lut_side  o_side,
    output logic [2:0][16:0]    o_lut
);

    function automatic logic [16:0] lerp(input logic [16:0] a, input logic [16:0] b,
                                         input logic [15:0] f);
        logic [16:0] wf;
        logic [34:0] acc;
        wf  = 17'd65536 - {1'b0, f};
        acc = 35'(a) * 35'(wf) + 35'(b) * 35'({1'b0, f}) + 35'd32768;
        return acc[32:16];
    endfunction

    cgl_pkg::t_tag      r_tag [3];
    cgl_pkg::t_lut_side r_side [3];
    logic [16:0]        w_wide [8][3];
    logic [16:0]        r12 [3][4];
    logic [16:0]        r13 [3][2];
    logic [2:0][16:0]   r14;

    always_comb begin
        for (int c = 0; c < 8; c++) begin
            for (int ch = 0; ch < 3; ch++) begin
                w_wide[c][ch] = 17'(i_rd[c][16*ch +: 16]) + 17'(i_rd[c][16*ch + 15]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < 3; s++) begin
                r_tag[s] <= '0;
            end
        end else if (i_en) begin
            r_tag[0] <= i_tag;
            r_tag[1] <= r_tag[0];
            r_tag[2] <= r_tag[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            r_side[1] <= r_side[0];
            r_side[2] <= r_side[1];
            for (int ch = 0; ch < 3; ch++) begin
                for (int j = 0; j < 4; j++) begin
                    r12[ch][j] <= lerp(w_wide[2*j][ch], w_wide[2*j+1][ch], i_side.fr[0]);
                end
                for (int m = 0; m < 2; m++) begin
                    r13[ch][m] <= lerp(r12[ch][2*m], r12[ch][2*m+1], r_side[0].fr[1]);
                end
                r14[ch] <= lerp(r13[ch][0], r13[ch][1], r_side[1].fr[2]);
            end
        end
    end

    assign o_tag  = r_tag[2];
    assign o_side = r_side[2];
    assign o_lut  = r14;

endmodule

FILE: hw/rtl/color_grade_lut_pixel.sv
// Top level of the colour grading pipeline with 3D LUT
// One item enters per clock unless the output buffer is full; a graded pixel leaves after
// its pixel item passes seven stages of grading arithmetic, three of LUT cell and corner
// addressing, one LUT read, three interpolation stages and the output register. LUT write
// items run down the same pipeline, update the LUT at the read stage and give no result,
// so they keep their order with pixels. The eight LUT corners come from four copies of the
// LUT, each read at two addresses per clock. LUT contents are undefined until written;
// there is no clearing pass. A two-entry output buffer lets the pipeline take one more item
// while a result waits; a full buffer stalls the whole pipeline. Configuration writes are
// taken at any time but must only be made while the pipeline is empty.
`include "assert_macros.svh"

module color_grade_lut_pixel #(
    parameter int LUT_DIM = cgl_pkg::LutDimDef
) (
    input logic         i_clk,
    input logic         i_rst_n,
    cgl_in_if.sink      i_in,
    cgl_out_if.source   o_out,
    cgl_cfg_if.sink     i_cfg
);

    localparam int AW = $clog2(LUT_DIM**3);

    cgl_pkg::t_cfg      r_cfg;
    logic               w_en;
    cgl_pkg::t_tag      w_in_tag;

    cgl_pkg::t_tag      w_g_tag;
    cgl_pkg::t_lut_wr   w_g_wr;
    logic [2:0][16:0]   w_g_v;
    cgl_pkg::t_tag      w_a_tag;
    cgl_pkg::t_lut_wr   w_a_wr;
    cgl_pkg::t_lut_side w_a_side;
    logic [AW-1:0]      w_addr [8];
    cgl_pkg::t_tag      w_m_tag;
    cgl_pkg::t_lut_side w_m_side;
    logic [47:0]        w_rd [8];
    cgl_pkg::t_tag      w_i_tag;
    cgl_pkg::t_lut_side w_i_side;
    logic [2:0][16:0]   w_lut;

    logic [16:0]        w_fin [3];
    logic [24:0]        w_scaled [3];
    logic               w_new_valid;
    cgl_pkg::t_out_item w_new_data;

    logic               r_out_valid;
    logic               n_out_valid;
    cgl_pkg::t_out_item r_out_data;
    cgl_pkg::t_out_item n_out_data;
    logic               r_skid_valid;
    logic               n_skid_valid;
    cgl_pkg::t_out_item r_skid_data;
    cgl_pkg::t_out_item n_skid_data;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.exposure_gain     <= 16'd4096;
            r_cfg.brightness_offset <= 14'sd0;
            r_cfg.contrast_gain     <= 16'd4096;
            r_cfg.saturation_gain   <= 16'd4096;
            r_cfg.lut_size          <= 6'd0;
        end else if (i_cfg.valid) begin
            case (cgl_pkg::t_cfg_idx'(i_cfg.index))
                cgl_pkg::CFG_EXPOSURE: begin
                    r_cfg.exposure_gain <= i_cfg.data;
                end
                cgl_pkg::CFG_BRIGHTNESS: begin
                    r_cfg.brightness_offset <= $signed(i_cfg.data[13:0]);
                end
                cgl_pkg::CFG_CONTRAST: begin
                    r_cfg.contrast_gain <= i_cfg.data;
                end
                cgl_pkg::CFG_SATURATION: begin
                    r_cfg.saturation_gain <= i_cfg.data;
                end
                cgl_pkg::CFG_LUT_SIZE: begin
                    r_cfg.lut_size <= i_cfg.data[5:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign w_en = !r_skid_valid;
    assign i_in.ready = w_en;
    assign w_in_tag.valid = i_in.valid && w_en;
    assign w_in_tag.pixel = !i_in.data.req_type;

    cgl_grade u_grade (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_tag   (w_in_tag),
        .i_item  (i_in.data),
        .i_cfg   (r_cfg),
        .o_tag   (w_g_tag),
        .o_wr    (w_g_wr),
        .o_v     (w_g_v)
    );

    cgl_lut_addr #(.LUT_DIM(LUT_DIM)) u_addr (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_lut_size (r_cfg.lut_size),
        .i_tag      (w_g_tag),
        .i_wr       (w_g_wr),
        .i_v        (w_g_v),
        .o_tag      (w_a_tag),
        .o_wr       (w_a_wr),
        .o_side     (w_a_side),
        .o_addr     (w_addr)
    );

    cgl_lut_mem #(.LUT_DIM(LUT_DIM)) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_tag   (w_a_tag),
        .i_wr    (w_a_wr),
        .i_side  (w_a_side),
        .i_addr  (w_addr),
        .o_tag   (w_m_tag),
        .o_side  (w_m_side),
        .o_rd    (w_rd)
    );

    cgl_interp u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_tag   (w_m_tag),
        .i_side  (w_m_side),
        .i_rd    (w_rd),
        .o_tag   (w_i_tag),
        .o_side  (w_i_side),
        .o_lut   (w_lut)
    );

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (!w_i_side.lut_en) begin
                w_fin[k] = w_i_side.v[k];
            end else if (w_lut[k] > 17'd65536) begin
                w_fin[k] = 17'd65536;
            end else begin
                w_fin[k] = w_lut[k];
            end
            w_scaled[k] = 25'(w_fin[k]) * 25'd255 + 25'd32768;
        end
        w_new_data.graded_red   = w_scaled[0][23:16];
        w_new_data.graded_green = w_scaled[1][23:16];
        w_new_data.graded_blue  = w_scaled[2][23:16];
        w_new_valid = w_i_tag.valid && w_i_tag.pixel && w_en;
    end

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_skid_valid = r_skid_valid;
        n_skid_data  = r_skid_data;
        if (!r_out_valid || o_out.ready) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out_data   = r_skid_data;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = w_new_valid;
                n_out_data  = w_new_data;
            end
        end else if (w_new_valid) begin
            n_skid_valid = 1'b1;
            n_skid_data  = w_new_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    `ASSERT_IMP(a_skid_needs_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `ASSERT_IMP(a_no_accept_when_full, i_clk, i_rst_n, r_skid_valid, !(i_in.valid && i_in.ready))
    `ASSERT_IMP(a_skid_fill_on_stall, i_clk, i_rst_n, $rose(r_skid_valid), $past(o_out.valid && !o_out.ready))
    `ASSERT_NXT(a_skid_drains, i_clk, i_rst_n, r_skid_valid && o_out.ready, r_out_valid && !r_skid_valid)

endmodule

FILE: tb/sv/tb_grade_checker.sv
// Checker for the colour grading pipeline: predicts graded pixels and compares them
`timescale 1ns / 100ps

module tb_grade_checker #(
    parameter int LUT_DIM = cgl_pkg::LutDimDef
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    cgl_in_if     in_ch,
    cgl_out_if    out_ch,
    cgl_cfg_if    cfg_ch,
    output int    o_fail_count,
    output int    o_pending
);

    localparam int Entries = LUT_DIM * LUT_DIM * LUT_DIM;

    logic [15:0]        lut_r [Entries];
    logic [15:0]        lut_g [Entries];
    logic [15:0]        lut_b [Entries];
    cgl_pkg::t_cfg      grade_cfg;
    cgl_pkg::t_out_item graded_q[$];

    function automatic longint rnd_shift(longint v, int n);
        longint half;
        half = longint'(1) << (n - 1);
        if (v >= 0) return (v + half) >>> n;
        return -((-v + half) >>> n);
    endfunction

    function automatic longint clamp_unit(longint v);
        if (v < 0) return 0;
        if (v > 65536) return 65536;
        return v;
    endfunction

    function automatic longint widen(logic [15:0] w);
        return longint'(w) + longint'(w[15]);
    endfunction

    function automatic longint blend(longint a, longint b, longint f);
        return (a * (65536 - f) + b * f + 32768) >>> 16;
    endfunction

    function automatic longint corner(int ch, longint s, longint x, longint y, longint z);
        longint idx;
        idx = z * s * s + y * s + x;
        if (idx >= Entries) return 0;
        case (ch)
            0: return widen(lut_r[idx]);
            1: return widen(lut_g[idx]);
            default: return widen(lut_b[idx]);
        endcase
    endfunction

    function automatic longint trilinear(int ch, longint s, longint i0[3], longint i1[3],
                                         longint fr[3]);
        longint c00, c10, c01, c11, c0, c1;
        c00 = blend(corner(ch, s, i0[0], i0[1], i0[2]), corner(ch, s, i1[0], i0[1], i0[2]), fr[0]);
        c10 = blend(corner(ch, s, i0[0], i1[1], i0[2]), corner(ch, s, i1[0], i1[1], i0[2]), fr[0]);
        c01 = blend(corner(ch, s, i0[0], i0[1], i1[2]), corner(ch, s, i1[0], i0[1], i1[2]), fr[0]);
        c11 = blend(corner(ch, s, i0[0], i1[1], i1[2]), corner(ch, s, i1[0], i1[1], i1[2]), fr[0]);
        c0 = blend(c00, c10, fr[1]);
        c1 = blend(c01, c11, fr[1]);
        return blend(c0, c1, fr[2]);
    endfunction

    function automatic cgl_pkg::t_out_item grade_pixel(cgl_pkg::t_in_item it);
        longint v[3], luma, s, p;
        longint i0[3], i1[3], fr[3];
        logic [7:0] px[3];
        cgl_pkg::t_out_item res;
        px[0] = it.pixel_red;
        px[1] = it.pixel_green;
        px[2] = it.pixel_blue;
        for (int k = 0; k < 3; k++) begin
            v[k] = longint'(px[k]) * 257;
            v[k] = rnd_shift(v[k] * longint'(grade_cfg.exposure_gain), 12);
            v[k] += longint'(grade_cfg.brightness_offset) * 16;
            v[k] = rnd_shift((v[k] - 32768) * longint'(grade_cfg.contrast_gain), 12) + 32768;
        end
        luma = rnd_shift(13933 * v[0] + 46871 * v[1] + 4732 * v[2], 16);
        for (int k = 0; k < 3; k++)
            v[k] = clamp_unit(luma + rnd_shift((v[k] - luma)
                   * longint'(grade_cfg.saturation_gain), 12));
        s = (grade_cfg.lut_size > LUT_DIM) ? LUT_DIM : grade_cfg.lut_size;
        if (s >= 2) begin
            for (int k = 0; k < 3; k++) begin
                p = v[k] * (s - 1);
                i0[k] = p >>> 16;
                fr[k] = p & 65535;
                if (i0[k] >= s - 1) begin
                    i0[k] = s - 1;
                    fr[k] = 0;
                end
                i1[k] = (i0[k] + 1 > s - 1) ? s - 1 : i0[k] + 1;
            end
            for (int k = 0; k < 3; k++)
                v[k] = clamp_unit(trilinear(k, s, i0, i1, fr));
        end
        res.graded_red   = 8'((v[0] * 255 + 32768) >>> 16);
        res.graded_green = 8'((v[1] * 255 + 32768) >>> 16);
        res.graded_blue  = 8'((v[2] * 255 + 32768) >>> 16);
        return res;
    endfunction

    assign o_pending = graded_q.size();

    always @(posedge i_clk) begin
        cgl_pkg::t_out_item exp_px;
        if (!i_rst_n) begin
            grade_cfg.exposure_gain     <= 16'd4096;
            grade_cfg.brightness_offset <= '0;
            grade_cfg.contrast_gain     <= 16'd4096;
            grade_cfg.saturation_gain   <= 16'd4096;
            grade_cfg.lut_size          <= '0;
            graded_q.delete();
            o_fail_count <= 0;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cgl_pkg::t_cfg_idx'(cfg_ch.index))
                    cgl_pkg::CFG_EXPOSURE:   grade_cfg.exposure_gain     <= cfg_ch.data;
                    cgl_pkg::CFG_BRIGHTNESS: grade_cfg.brightness_offset <= cfg_ch.data[13:0];
                    cgl_pkg::CFG_CONTRAST:   grade_cfg.contrast_gain     <= cfg_ch.data;
                    cgl_pkg::CFG_SATURATION: grade_cfg.saturation_gain   <= cfg_ch.data;
                    cgl_pkg::CFG_LUT_SIZE:   grade_cfg.lut_size          <= cfg_ch.data[5:0];
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready) begin
                if (in_ch.data.req_type) begin
                    if (in_ch.data.lut_address < Entries) begin
                        lut_r[in_ch.data.lut_address] = in_ch.data.lut_red;
                        lut_g[in_ch.data.lut_address] = in_ch.data.lut_green;
                        lut_b[in_ch.data.lut_address] = in_ch.data.lut_blue;
                    end
                end else begin
                    graded_q = {graded_q, grade_pixel(in_ch.data)};
                end
            end
            if (out_ch.valid && out_ch.ready) begin
                if (graded_q.size() == 0) begin
                    $display("%0t: unexpected graded pixel %h", $time, out_ch.data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_px = graded_q.pop_front();
                    if (exp_px !== out_ch.data) begin
                        $display("%0t: graded pixel mismatch, expected %h actual %h",
                                 $time, exp_px, out_ch.data);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

FILE: tb/sv/tb.sv
// Testbench top: stimulus, configuration phases and verdict for the grading pipeline
`timescale 1ns / 100ps

module tb;

    localparam int Dim = cgl_pkg::LutDimDef;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count;
    int   pending;
    bit   sink_busy = 1'b1;
    bit   calm = 1'b0;

    cgl_in_if  in_ch ();
    cgl_out_if out_ch ();
    cgl_cfg_if cfg_ch ();

    color_grade_lut_pixel #(.LUT_DIM(Dim)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    tb_grade_checker #(.LUT_DIM(Dim)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .cfg_ch       (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data  = '0;
        out_ch.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!sink_busy) out_ch.ready <= 1'b0;
        else if (calm) out_ch.ready <= 1'b1;
        else out_ch.ready <= ($urandom_range(99) >= 33);
    end

    task automatic send_item(cgl_pkg::t_in_item it);
        if (!calm) begin
            while ($urandom_range(99) < 33) begin
                in_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic write_reg(cgl_pkg::t_cfg_idx idx, logic [15:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        cgl_pkg::t_in_item it;
        it = '0;
        it.pixel_red   = r;
        it.pixel_green = g;
        it.pixel_blue  = b;
        it.lut_address = 16'($urandom);
        it.lut_red     = 16'($urandom);
        send_item(it);
    endtask

    task automatic send_lut(logic [15:0] addr, logic [15:0] r, logic [15:0] g,
                            logic [15:0] b);
        cgl_pkg::t_in_item it;
        it.req_type    = 1'b1;
        it.pixel_red   = 8'($urandom);
        it.pixel_green = 8'($urandom);
        it.pixel_blue  = 8'($urandom);
        it.lut_address = addr;
        it.lut_red     = r;
        it.lut_green   = g;
        it.lut_blue    = b;
        send_item(it);
    endtask

    // fill the whole cube of a given size with random entries
    task automatic fill_cube(int sz);
        for (int a = 0; a < sz * sz * sz; a++)
            send_lut(16'(a), 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // fill the eight corners around mid grey of the full-size cube
    task automatic fill_mid();
        int m;
        m = (Dim - 1) / 2;
        for (int c = 0; c < 8; c++)
            send_lut(16'((m + c / 4) * Dim * Dim + (m + (c / 2) % 2) * Dim + m + c % 2),
                     16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic random_pixels(int n);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(9) == 0)
                send_lut(16'($urandom_range(65535, Dim * Dim * Dim)), 16'($urandom),
                         16'($urandom), 16'($urandom));
            else
                send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    task automatic set_grade(logic [15:0] ex, logic [15:0] br, logic [15:0] co,
                             logic [15:0] sa, logic [15:0] sz);
        write_reg(cgl_pkg::CFG_EXPOSURE, ex);
        write_reg(cgl_pkg::CFG_BRIGHTNESS, br);
        write_reg(cgl_pkg::CFG_CONTRAST, co);
        write_reg(cgl_pkg::CFG_SATURATION, sa);
        write_reg(cgl_pkg::CFG_LUT_SIZE, sz);
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_pixel(8'h00, 8'h00, 8'h00);
        send_pixel(8'hff, 8'hff, 8'hff);
        send_pixel(8'hff, 8'h00, 8'h80);
        send_pixel(8'h55, 8'haa, 8'h01);
        send_lut(16'hffff, 16'hffff, 16'hffff, 16'hffff);
        send_lut(16'(Dim * Dim * Dim), 16'h1234, 16'h5678, 16'h9abc);
        drain();

        set_grade(16'd8192, 16'h3000, 16'd6000, 16'd2048, 16'd2);
        fill_cube(2);
        send_pixel(8'h00, 8'h00, 8'h00);
        send_pixel(8'hff, 8'hff, 8'hff);
        send_pixel(8'h7f, 8'h80, 8'h81);
        random_pixels(60);
        drain();

        // oversize LUT size is capped at full size; zero contrast holds pixels at mid grey
        set_grade(16'd8192, 16'h0100, 16'd0, 16'd4096, 16'd63);
        fill_mid();
        send_pixel(8'hff, 8'hff, 8'hff);
        random_pixels(40);
        drain();

        set_grade(16'hffff, 16'h2000, 16'hffff, 16'hffff, 16'd0);
        random_pixels(40);
        drain();
        set_grade(16'd0, 16'h1fff, 16'd0, 16'd0, 16'd1);
        random_pixels(30);
        drain();
        set_grade(16'd3000, 16'h0400, 16'd5000, 16'd7000, 16'd4);
        fill_cube(4);
        random_pixels(70);
        calm = 1'b1;
        random_pixels(60);
        calm = 1'b0;
        drain();
        set_grade(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'd0);
        random_pixels(60);
        drain();
        sink_busy = 1'b1;

        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end
endmodule
